// File: sv/nfsw_pkg.sv
// ----------------------------------------------------------------------------
// nfsw_pkg: shared constants and types for the stencil weights unit
// widths of positions, products, quotients and the lane record handed to the
// pipelined dividers
// ----------------------------------------------------------------------------
package nfsw_pkg;

  localparam int POS_W         = 24;
  localparam int POS_FRAC_BITS = 16;
  localparam int W_FRAC        = 24;
  localparam int Q_W           = 40;

  localparam int EXT_W  = POS_W + 1;
  localparam int PAIR_W = 2 * POS_W;
  localparam int TRIP_W = 3 * POS_W;
  localparam int D_W    = TRIP_W;
  localparam int NUMS_W = 3 * (POS_W - 1) + 1 + W_FRAC;
  localparam int X_W    = NUMS_W + 2;
  localparam int Y_W    = D_W + 1;
  localparam int DIV_W  = Y_W + Q_W;

  // neumann polynomial terms
  localparam int A_W  = POS_W + 3;
  localparam int C_W  = POS_W + 2;
  localparam int S_W  = POS_W + 1;
  localparam int N2_W = POS_W + 3;
  localparam int PA_W = A_W + POS_W;
  localparam int PC_W = C_W + POS_W;
  localparam int PB_W = 2 * POS_W;
  localparam int PS_W = S_W + POS_W;
  localparam int P_W  = 2 * POS_W + 4;
  localparam int N1_W = 2 * POS_W + 2;

  // numerator scaling per weight
  localparam int SH_DIR = W_FRAC;
  localparam int SH_NB  = W_FRAC - POS_FRAC_BITS;
  localparam int SH_N1  = W_FRAC;
  localparam int SH_N2  = W_FRAC + POS_FRAC_BITS;
  localparam int SH_N3  = W_FRAC + 2 * POS_FRAC_BITS;
  localparam int NEU_CONST = 6;

  // register stages: 4 front, operand, range check, one per quotient bit, saturation
  localparam int NST = Q_W + 7;

  localparam logic KIND_DIRICHLET = 1'b0;
  localparam logic KIND_NEUMANN   = 1'b1;

  typedef logic [POS_W-1:0] mag_t;

  typedef struct packed {
    logic [NUMS_W-1:0] num;
    logic [D_W-1:0]    den;
    logic              neg;
    logic              degen;
  } lane_t;

  function automatic mag_t mag_of(input logic signed [EXT_W-1:0] v);
    logic [EXT_W-1:0] n;
    n = v[EXT_W-1] ? EXT_W'(-v) : EXT_W'(v);
    return n[POS_W-1:0];
  endfunction

endpackage

// File: sv/nfsw_front.sv
// ----------------------------------------------------------------------------
// nfsw_front: operand preparation for the four divider lanes
// differences, pairwise and triple products, neumann polynomial, then selects
// numerator, denominator and sign per weight over four register stages
// ----------------------------------------------------------------------------
module nfsw_front (
  input  logic                                clk,
  input  logic                                adv,
  input  logic                                kind_i,
  input  logic signed [nfsw_pkg::POS_W-1:0]   pos_boundary_i,
  input  logic signed [nfsw_pkg::POS_W-1:0]   pos_first_i,
  input  logic signed [nfsw_pkg::POS_W-1:0]   pos_second_i,
  input  logic signed [nfsw_pkg::POS_W-1:0]   pos_third_i,
  output nfsw_pkg::lane_t                     lane_o [4]
);
  import nfsw_pkg::*;

  // stage 0: magnitudes, differences, neumann sums
  logic signed [EXT_W-1:0] pos_x [4];
  logic signed [EXT_W-1:0] dif [6];
  logic signed [A_W-1:0]   a_nxt;
  logic signed [C_W-1:0]   c_nxt;
  logic signed [S_W-1:0]   s12_nxt;
  logic signed [N2_W-1:0]  n2_nxt;

  logic                    s0_kind_r;
  mag_t                    s0_pmag_r [4];
  logic                    s0_psgn_r [4];
  mag_t                    s0_dmag_r [6];
  logic                    s0_dsgn_r [6];
  logic signed [POS_W-1:0] s0_pos_r [4];
  logic signed [A_W-1:0]   s0_a_r;
  logic signed [C_W-1:0]   s0_c_r;
  logic signed [S_W-1:0]   s0_s12_r;
  logic signed [N2_W-1:0]  s0_n2_r;

  assign pos_x[0] = EXT_W'(pos_boundary_i);
  assign pos_x[1] = EXT_W'(pos_first_i);
  assign pos_x[2] = EXT_W'(pos_second_i);
  assign pos_x[3] = EXT_W'(pos_third_i);

  // d10 d20 d30 d21 d13 d32
  assign dif[0] = pos_x[1] - pos_x[0];
  assign dif[1] = pos_x[2] - pos_x[0];
  assign dif[2] = pos_x[3] - pos_x[0];
  assign dif[3] = pos_x[2] - pos_x[1];
  assign dif[4] = pos_x[1] - pos_x[3];
  assign dif[5] = pos_x[3] - pos_x[2];

  assign a_nxt   = A_W'(pos_second_i) + A_W'(pos_first_i) - (A_W'(pos_boundary_i) <<< 1);
  assign c_nxt   = C_W'(pos_first_i) - (C_W'(pos_boundary_i) <<< 1);
  assign s12_nxt = S_W'(pos_first_i) + S_W'(pos_second_i);
  assign n2_nxt  = (N2_W'(pos_first_i) + N2_W'(pos_second_i) + N2_W'(pos_third_i)) <<< 1;

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_kind_r <= kind_i;
      for (int j = 0; j < 4; j++) begin
        s0_pmag_r[j] <= mag_of(pos_x[j]);
        s0_psgn_r[j] <= pos_x[j][EXT_W-1];
      end
      for (int j = 0; j < 6; j++) begin
        s0_dmag_r[j] <= mag_of(dif[j]);
        s0_dsgn_r[j] <= dif[j][EXT_W-1];
      end
      s0_pos_r[0] <= pos_boundary_i;
      s0_pos_r[1] <= pos_first_i;
      s0_pos_r[2] <= pos_second_i;
      s0_pos_r[3] <= pos_third_i;
      s0_a_r      <= a_nxt;
      s0_c_r      <= c_nxt;
      s0_s12_r    <= s12_nxt;
      s0_n2_r     <= n2_nxt;
    end
  end

  // stage 1: pairwise products
  logic                    s1_kind_r;
  logic [PAIR_W-1:0]       s1_np_r [4];
  logic [PAIR_W-1:0]       s1_dp_r [4];
  mag_t                    s1_nt_r [4];
  mag_t                    s1_dt_r [4];
  logic                    s1_neg_r [4];
  logic                    s1_nn_r;
  logic signed [PA_W-1:0]  s1_pa_r;
  logic signed [PC_W-1:0]  s1_pc_r;
  logic signed [PB_W-1:0]  s1_pbf_r;
  logic signed [PB_W-1:0]  s1_pbb_r;
  logic signed [PS_W-1:0]  s1_ps_r;
  logic signed [PB_W-1:0]  s1_pf_r;
  logic signed [N2_W-1:0]  s1_n2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r  <= s0_kind_r;
      s1_np_r[0] <= PAIR_W'(s0_pmag_r[1]) * PAIR_W'(s0_pmag_r[2]);
      s1_np_r[1] <= PAIR_W'(s0_pmag_r[0]) * PAIR_W'(s0_pmag_r[2]);
      s1_np_r[2] <= PAIR_W'(s0_pmag_r[0]) * PAIR_W'(s0_pmag_r[1]);
      s1_np_r[3] <= PAIR_W'(s0_pmag_r[0]) * PAIR_W'(s0_pmag_r[1]);
      s1_nt_r[0] <= s0_pmag_r[3];
      s1_nt_r[1] <= s0_pmag_r[3];
      s1_nt_r[2] <= s0_pmag_r[3];
      s1_nt_r[3] <= s0_pmag_r[2];
      s1_dp_r[0] <= PAIR_W'(s0_dmag_r[0]) * PAIR_W'(s0_dmag_r[1]);
      s1_dp_r[1] <= PAIR_W'(s0_dmag_r[0]) * PAIR_W'(s0_dmag_r[3]);
      s1_dp_r[2] <= PAIR_W'(s0_dmag_r[1]) * PAIR_W'(s0_dmag_r[3]);
      s1_dp_r[3] <= PAIR_W'(s0_dmag_r[2]) * PAIR_W'(s0_dmag_r[4]);
      s1_dt_r[0] <= s0_dmag_r[2];
      s1_dt_r[1] <= s0_dmag_r[4];
      s1_dt_r[2] <= s0_dmag_r[5];
      s1_dt_r[3] <= s0_dmag_r[5];
      s1_neg_r[0] <= s0_psgn_r[1] ^ s0_psgn_r[2] ^ s0_psgn_r[3]
                   ^ s0_dsgn_r[0] ^ s0_dsgn_r[1] ^ s0_dsgn_r[2];
      s1_neg_r[1] <= s0_psgn_r[0] ^ s0_psgn_r[2] ^ s0_psgn_r[3]
                   ^ s0_dsgn_r[0] ^ s0_dsgn_r[3] ^ s0_dsgn_r[4];
      s1_neg_r[2] <= s0_psgn_r[0] ^ s0_psgn_r[1] ^ s0_psgn_r[3]
                   ^ s0_dsgn_r[1] ^ s0_dsgn_r[3] ^ s0_dsgn_r[5];
      s1_neg_r[3] <= s0_psgn_r[0] ^ s0_psgn_r[1] ^ s0_psgn_r[2]
                   ^ s0_dsgn_r[2] ^ s0_dsgn_r[4] ^ s0_dsgn_r[5];
      s1_nn_r    <= s0_psgn_r[1] ^ s0_psgn_r[2] ^ s0_psgn_r[3];
      s1_pa_r    <= PA_W'(s0_a_r) * PA_W'(s0_pos_r[3]);
      s1_pc_r    <= PC_W'(s0_c_r) * PC_W'(s0_pos_r[2]);
      s1_pbf_r   <= PB_W'(s0_pos_r[0]) * PB_W'(s0_pos_r[1]);
      s1_pbb_r   <= PB_W'(s0_pos_r[0]) * PB_W'(s0_pos_r[0]);
      s1_ps_r    <= PS_W'(s0_s12_r) * PS_W'(s0_pos_r[3]);
      s1_pf_r    <= PB_W'(s0_pos_r[1]) * PB_W'(s0_pos_r[2]);
      s1_n2_r    <= s0_n2_r;
    end
  end

  // stage 2: triple products, neumann divisor and first numerator
  logic                    s2_kind_r;
  logic [TRIP_W-1:0]       s2_ntrip_r [4];
  logic [TRIP_W-1:0]       s2_dtrip_r [4];
  logic                    s2_neg_r [4];
  logic                    s2_nn_r;
  logic signed [P_W-1:0]   s2_p_r;
  logic signed [N1_W-1:0]  s2_n1_r;
  logic signed [N2_W-1:0]  s2_n2_r;
  logic signed [P_W-1:0]   p_nxt;
  logic signed [N1_W-1:0]  n1_nxt;

  assign p_nxt = P_W'(s1_pa_r) + P_W'(s1_pc_r) - (P_W'(s1_pbf_r) <<< 1)
               + (P_W'(s1_pbb_r) <<< 1) + P_W'(s1_pbb_r);
  assign n1_nxt = N1_W'(s1_ps_r) + N1_W'(s1_pf_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_kind_r <= s1_kind_r;
      for (int j = 0; j < 4; j++) begin
        s2_ntrip_r[j] <= TRIP_W'(s1_np_r[j]) * TRIP_W'(s1_nt_r[j]);
        s2_dtrip_r[j] <= TRIP_W'(s1_dp_r[j]) * TRIP_W'(s1_dt_r[j]);
        s2_neg_r[j]   <= s1_neg_r[j];
      end
      s2_nn_r <= s1_nn_r;
      s2_p_r  <= p_nxt;
      s2_n1_r <= n1_nxt;
      s2_n2_r <= s1_n2_r;
    end
  end

  // stage 3: per-weight operand selection
  lane_t            s3_lane_r [4];
  lane_t            lane_nxt [4];
  logic [P_W-1:0]   p_abs;
  logic [N1_W-1:0]  n1_abs;
  logic [N2_W-1:0]  n2_abs;
  logic             dn;
  logic             dir_degen;
  logic             neu_degen;

  always_comb begin
    dn        = s2_p_r[P_W-1];
    p_abs     = dn ? P_W'(-s2_p_r) : P_W'(s2_p_r);
    n1_abs    = s2_n1_r[N1_W-1] ? N1_W'(-s2_n1_r) : N1_W'(s2_n1_r);
    n2_abs    = s2_n2_r[N2_W-1] ? N2_W'(-s2_n2_r) : N2_W'(s2_n2_r);
    dir_degen = (s2_dtrip_r[0] == '0) || (s2_dtrip_r[1] == '0)
             || (s2_dtrip_r[2] == '0) || (s2_dtrip_r[3] == '0);
    neu_degen = (s2_p_r == '0);
    case (s2_kind_r)
      KIND_DIRICHLET: begin
        for (int j = 0; j < 4; j++) begin
          lane_nxt[j].num   = NUMS_W'(s2_ntrip_r[j]) << SH_DIR;
          lane_nxt[j].den   = s2_dtrip_r[j];
          lane_nxt[j].neg   = s2_neg_r[j];
          lane_nxt[j].degen = dir_degen;
        end
      end
      default: begin
        for (int j = 0; j < 4; j++) begin
          lane_nxt[j].den   = D_W'(p_abs);
          lane_nxt[j].degen = neu_degen;
        end
        lane_nxt[0].num = NUMS_W'(s2_ntrip_r[0]) << SH_NB;
        lane_nxt[0].neg = ~s2_nn_r ^ dn;
        lane_nxt[1].num = NUMS_W'(n1_abs) << SH_N1;
        lane_nxt[1].neg = s2_n1_r[N1_W-1] ^ dn;
        lane_nxt[2].num = NUMS_W'(n2_abs) << SH_N2;
        lane_nxt[2].neg = ~s2_n2_r[N2_W-1] ^ dn;
        lane_nxt[3].num = NUMS_W'(NEU_CONST) << SH_N3;
        lane_nxt[3].neg = dn;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) s3_lane_r[j] <= lane_nxt[j];
    end
  end

  assign lane_o = s3_lane_r;

endmodule

// File: sv/nfsw_div.sv
// ----------------------------------------------------------------------------
// nfsw_div: one weight lane, rounded quotient with saturation
// forms 2n+d over 2d, checks the quotient range, then one restoring step per
// quotient bit in its own register stage, then clamps and applies the sign
// ----------------------------------------------------------------------------
module nfsw_div (
  input  logic                             clk,
  input  logic                             adv,
  input  nfsw_pkg::lane_t                  lane_i,
  output logic signed [nfsw_pkg::Q_W-1:0]  weight_o,
  output logic                             clip_o,
  output logic                             degen_o
);
  import nfsw_pkg::*;

  // operand stage
  logic [X_W-1:0] x_r;
  logic [Y_W-1:0] yx_r;
  logic           negx_r;
  logic           dgnx_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      x_r    <= (X_W'(lane_i.num) << 1) + X_W'(lane_i.den);
      yx_r   <= {lane_i.den, 1'b0};
      negx_r <= lane_i.neg;
      dgnx_r <= lane_i.degen;
    end
  end

  // range check stage, index 0 of the step arrays
  logic [X_W-1:0] rem_r [Q_W+1];
  logic [Y_W-1:0] dy_r  [Q_W+1];
  logic [Q_W-1:0] quo_r [Q_W+1];
  logic           ovf_r [Q_W+1];
  logic           neg_r [Q_W+1];
  logic           dgn_r [Q_W+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r[0] <= x_r;
      dy_r[0]  <= yx_r;
      quo_r[0] <= '0;
      ovf_r[0] <= DIV_W'(x_r) >= {yx_r, {Q_W{1'b0}}};
      neg_r[0] <= negx_r;
      dgn_r[0] <= dgnx_r;
    end
  end

  // restoring steps, msb first
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    localparam int BIT = Q_W - 1 - k;
    logic [DIV_W:0] diff;
    logic [Q_W-1:0] q_nxt;

    assign diff = {1'b0, DIV_W'(rem_r[k])} - {1'b0, DIV_W'(dy_r[k]) << BIT};

    always_comb begin
      q_nxt      = quo_r[k];
      q_nxt[BIT] = ~diff[DIV_W];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k+1] <= diff[DIV_W] ? rem_r[k] : diff[X_W-1:0];
        dy_r[k+1]  <= dy_r[k];
        quo_r[k+1] <= q_nxt;
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
        dgn_r[k+1] <= dgn_r[k];
      end
    end
  end

  // saturation and sign
  logic [Q_W-1:0] lim;
  logic           sat;
  logic [Q_W-1:0] mq;
  logic [Q_W-1:0] w_nxt;
  logic [Q_W-1:0] weight_r;
  logic           clip_r;
  logic           degen_r;

  always_comb begin
    lim   = neg_r[Q_W] ? (Q_W'(1) << (Q_W - 1)) : ((Q_W'(1) << (Q_W - 1)) - Q_W'(1));
    sat   = ovf_r[Q_W] || (quo_r[Q_W] > lim);
    mq    = sat ? lim : quo_r[Q_W];
    w_nxt = neg_r[Q_W] ? Q_W'(-mq) : mq;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      weight_r <= dgn_r[Q_W] ? '0 : w_nxt;
      clip_r   <= ~dgn_r[Q_W] & sat;
      degen_r  <= dgn_r[Q_W];
    end
  end

  assign weight_o = weight_r;
  assign clip_o   = clip_r;
  assign degen_o  = degen_r;

endmodule

// File: sv/nonuniform_four_point_stencil_weights_unit.sv
// ----------------------------------------------------------------------------
// nonuniform_four_point_stencil_weights_unit: boundary stencil weights
// dirichlet lagrange weights or neumann derivative weights from four grid
// positions, four pipelined dividers, saturating q16.24 results
// ----------------------------------------------------------------------------
// pipeline from input transaction to out_valid: 4 operand stages, operand and
//   range-check stages, 40 quotient-bit stages, saturation, output
// throughput: one transaction per cycle while the skid entry is empty, set by the
//   40-stage restoring divider retiring one quotient bit per stage in four lanes
// reset: synchronous active low, clears stage valid bits and output/skid flags
// ----------------------------------------------------------------------------
module nonuniform_four_point_stencil_weights_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_kind,
  input  logic signed [nfsw_pkg::POS_W-1:0] in_pos_boundary,
  input  logic signed [nfsw_pkg::POS_W-1:0] in_pos_first,
  input  logic signed [nfsw_pkg::POS_W-1:0] in_pos_second,
  input  logic signed [nfsw_pkg::POS_W-1:0] in_pos_third,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [nfsw_pkg::Q_W-1:0]   out_weight_boundary,
  output logic signed [nfsw_pkg::Q_W-1:0]   out_weight_first,
  output logic signed [nfsw_pkg::Q_W-1:0]   out_weight_second,
  output logic signed [nfsw_pkg::Q_W-1:0]   out_weight_third,
  output logic                              out_degenerate,
  output logic                              out_clipped
);
  import nfsw_pkg::*;

  typedef struct packed {
    logic [Q_W-1:0] w0;
    logic [Q_W-1:0] w1;
    logic [Q_W-1:0] w2;
    logic [Q_W-1:0] w3;
    logic           degen;
    logic           clip;
  } res_t;

  // the whole pipeline moves together unless the skid stage is holding
  logic           adv;
  logic [NST-1:0] vld_r;

  lane_t                 lane [4];
  logic signed [Q_W-1:0] w_lane [4];
  logic                  clip_lane [4];
  logic                  dgn_lane [4];

  nfsw_front u_front (
    .clk            (clk),
    .adv            (adv),
    .kind_i         (in_kind),
    .pos_boundary_i (in_pos_boundary),
    .pos_first_i    (in_pos_first),
    .pos_second_i   (in_pos_second),
    .pos_third_i    (in_pos_third),
    .lane_o         (lane)
  );

  // one divider per weight
  for (genvar l = 0; l < 4; l++) begin : g_lane
    nfsw_div u_div (
      .clk      (clk),
      .adv      (adv),
      .lane_i   (lane[l]),
      .weight_o (w_lane[l]),
      .clip_o   (clip_lane[l]),
      .degen_o  (dgn_lane[l])
    );
  end

  // valid bits travel alongside the data stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  // output register plus one skid entry, so a stalled result does not
  // stop the next transaction from entering
  res_t pipe_d;
  logic pipe_v;
  logic take;
  logic push;
  logic out_v_r, out_v_nxt;
  logic skid_v_r, skid_v_nxt;
  res_t out_d_r, out_d_nxt;
  res_t skid_d_r, skid_d_nxt;

  assign pipe_v       = vld_r[NST-1];
  assign pipe_d.w0    = w_lane[0];
  assign pipe_d.w1    = w_lane[1];
  assign pipe_d.w2    = w_lane[2];
  assign pipe_d.w3    = w_lane[3];
  assign pipe_d.degen = dgn_lane[0];
  assign pipe_d.clip  = clip_lane[0] | clip_lane[1] | clip_lane[2] | clip_lane[3];

  assign adv  = ~skid_v_r;
  assign take = out_v_r & out_ready;
  assign push = adv & pipe_v;

  always_comb begin
    out_v_nxt  = out_v_r;
    out_d_nxt  = out_d_r;
    skid_v_nxt = skid_v_r;
    skid_d_nxt = skid_d_r;
    if (skid_v_r) begin
      if (take) begin
        out_d_nxt  = skid_d_r;
        skid_v_nxt = 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || take) begin
        out_v_nxt = 1'b1;
        out_d_nxt = pipe_d;
      end else begin
        skid_v_nxt = 1'b1;
        skid_d_nxt = pipe_d;
      end
    end else if (take) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    out_d_r  <= out_d_nxt;
    skid_d_r <= skid_d_nxt;
  end

  assign in_ready            = adv;
  assign out_valid           = out_v_r;
  assign out_weight_boundary = out_d_r.w0;
  assign out_weight_first    = out_d_r.w1;
  assign out_weight_second   = out_d_r.w2;
  assign out_weight_third    = out_d_r.w3;
  assign out_degenerate      = out_d_r.degen;
  assign out_clipped         = out_d_r.clip;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the nonuniform four point stencil weights unit
// sends position sets with random gaps, predicts each weight set with wide
// exact arithmetic, and checks every output transaction field by field
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfsw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic [Q_W-1:0] w_boundary;
    logic [Q_W-1:0] w_first;
    logic [Q_W-1:0] w_second;
    logic [Q_W-1:0] w_third;
    logic           degenerate;
    logic           clipped;
  } stencil_weights_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_kind = KIND_DIRICHLET;
  logic signed [POS_W-1:0] in_pos_boundary = '0;
  logic signed [POS_W-1:0] in_pos_first = '0;
  logic signed [POS_W-1:0] in_pos_second = '0;
  logic signed [POS_W-1:0] in_pos_third = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [Q_W-1:0] out_weight_boundary;
  logic signed [Q_W-1:0] out_weight_first;
  logic signed [Q_W-1:0] out_weight_second;
  logic signed [Q_W-1:0] out_weight_third;
  logic out_degenerate;
  logic out_clipped;

  stencil_weights_t expected_weights[$];
  int  mismatches = 0;
  int  sent_count = 0;
  int  checked_count = 0;
  int  degenerate_seen = 0;
  int  clipped_seen = 0;
  int  cycle_count = 0;
  bit  no_idle = 1'b0;
  logic in_fire = 1'b0;

  nonuniform_four_point_stencil_weights_unit uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_pos_boundary     (in_pos_boundary),
    .in_pos_first        (in_pos_first),
    .in_pos_second       (in_pos_second),
    .in_pos_third        (in_pos_third),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_weight_boundary (out_weight_boundary),
    .out_weight_first    (out_weight_first),
    .out_weight_second   (out_weight_second),
    .out_weight_third    (out_weight_third),
    .out_degenerate      (out_degenerate),
    .out_clipped         (out_clipped)
  );

  always #10 clk = ~clk;

  // magnitude of x*y*z, wide enough for any position triple
  function automatic logic [191:0] triple_mag(longint x, longint y, longint z);
    logic [191:0] ax, ay, az;
    ax = 192'(x < 0 ? -x : x);
    ay = 192'(y < 0 ? -y : y);
    az = 192'(z < 0 ? -z : z);
    return ax * ay * az;
  endfunction

  // exact quotient scaled by 2^sh, rounded half away from zero, clamped to q16.24
  function automatic logic [Q_W-1:0] round_weight(bit neg, logic [191:0] num,
                                                  logic [191:0] den, int sh,
                                                  inout bit clip);
    logic [191:0] q, lim;
    lim = neg ? (192'd1 << (Q_W-1)) : (192'd1 << (Q_W-1)) - 192'd1;
    if (sh >= 0) num = num << sh;
    else den = den << (-sh);
    q = ((num << 1) + den) / (den << 1);
    if (q > lim) begin
      q = lim;
      clip = 1'b1;
    end
    return neg ? Q_W'(-q) : q[Q_W-1:0];
  endfunction

  function automatic stencil_weights_t predict_weights(logic kind, longint b, longint f1,
                                                       longint f2, longint f3);
    stencil_weights_t r;
    logic [191:0] dens[4];
    bit dneg[4];
    longint nf[4][3];
    longint df[4][3];
    longint p, n1, n2;
    bit clip, nn, dn;
    logic [Q_W-1:0] w[4];
    clip = 1'b0;
    w = '{default: '0};
    r.degenerate = 1'b0;
    if (kind == KIND_DIRICHLET) begin
      nf = '{'{f1, f2, f3}, '{b, f2, f3}, '{b, f1, f3}, '{b, f1, f2}};
      df = '{'{f1-b, f2-b, f3-b}, '{f1-b, f2-f1, f1-f3},
             '{f2-b, f2-f1, f3-f2}, '{f3-b, f1-f3, f3-f2}};
      for (int i = 0; i < 4; i++) begin
        dens[i] = triple_mag(df[i][0], df[i][1], df[i][2]);
        dneg[i] = (df[i][0] < 0) ^ (df[i][1] < 0) ^ (df[i][2] < 0);
        if (dens[i] == 0) r.degenerate = 1'b1;
      end
      if (!r.degenerate) begin
        for (int i = 0; i < 4; i++) begin
          nn = (nf[i][0] < 0) ^ (nf[i][1] < 0) ^ (nf[i][2] < 0);
          w[i] = round_weight(nn != dneg[i], triple_mag(nf[i][0], nf[i][1], nf[i][2]),
                              dens[i], W_FRAC, clip);
        end
      end
    end else begin
      p = (f2 + f1 - 2*b) * f3 + (f1 - 2*b) * f2 - 2*b*f1 + 3*b*b;
      if (p == 0) begin
        r.degenerate = 1'b1;
      end else begin
        n1 = (f2 + f1) * f3 + f1 * f2;
        n2 = 2*f3 + 2*f2 + 2*f1;
        dn = p < 0;
        dens[0] = 192'(p < 0 ? -p : p);
        nn = (f1 < 0) ^ (f2 < 0) ^ (f3 < 0);
        w[0] = round_weight(!nn != dn, triple_mag(f1, f2, f3), dens[0],
                            W_FRAC - POS_FRAC_BITS, clip);
        w[1] = round_weight((n1 < 0) != dn, 192'(n1 < 0 ? -n1 : n1), dens[0],
                            W_FRAC, clip);
        w[2] = round_weight(!(n2 < 0) != dn, 192'(n2 < 0 ? -n2 : n2), dens[0],
                            W_FRAC + POS_FRAC_BITS, clip);
        w[3] = round_weight(dn, 192'd6, dens[0], W_FRAC + 2*POS_FRAC_BITS, clip);
      end
    end
    r.w_boundary = w[0];
    r.w_first    = w[1];
    r.w_second   = w[2];
    r.w_third    = w[3];
    r.clipped    = clip;
    return r;
  endfunction

  // input acceptance seen at the rising edge, read by the sender at the falling edge
  always @(posedge clk) in_fire <= in_valid && in_ready;

  // result side stalls about one cycle in ten unless idling is off
  always @(negedge clk) out_ready <= no_idle || ($urandom_range(99) >= 10);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_weights.size());
      $display("tb failed");
      $finish;
    end
  end

  task automatic report_mismatch(string field, logic [Q_W-1:0] got, logic [Q_W-1:0] want);
    mismatches++;
    $display("mismatch on %s at result %0d: got %h expected %h",
             field, checked_count, got, want);
  endtask

  // checks each output transaction against the oldest predicted weight set
  always @(posedge clk) begin
    stencil_weights_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_weights.size() == 0) begin
        mismatches++;
        $display("unexpected output transaction at cycle %0d", cycle_count);
      end else begin
        want = expected_weights.pop_front();
        if (out_weight_boundary !== want.w_boundary)
          report_mismatch("weight_boundary", out_weight_boundary, want.w_boundary);
        if (out_weight_first !== want.w_first)
          report_mismatch("weight_first", out_weight_first, want.w_first);
        if (out_weight_second !== want.w_second)
          report_mismatch("weight_second", out_weight_second, want.w_second);
        if (out_weight_third !== want.w_third)
          report_mismatch("weight_third", out_weight_third, want.w_third);
        if (out_degenerate !== want.degenerate)
          report_mismatch("degenerate", Q_W'(out_degenerate), Q_W'(want.degenerate));
        if (out_clipped !== want.clipped)
          report_mismatch("clipped", Q_W'(out_clipped), Q_W'(want.clipped));
        if (want.degenerate) degenerate_seen++;
        if (want.clipped) clipped_seen++;
        checked_count++;
      end
    end
  end

  // one input transaction; starts and returns just after a falling edge
  task automatic send_stencil(logic kind, longint b, longint f1, longint f2, longint f3);
    while (!no_idle && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    expected_weights.push_back(predict_weights(kind, b, f1, f2, f3));
    in_kind         <= kind;
    in_pos_boundary <= POS_W'(b);
    in_pos_first    <= POS_W'(f1);
    in_pos_second   <= POS_W'(f2);
    in_pos_third    <= POS_W'(f3);
    in_valid        <= 1'b1;
    do @(negedge clk); while (!in_fire);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_weights.size() != 0) @(negedge clk);
  endtask

  function automatic longint rand_pos();
    return longint'($signed(24'($urandom)));
  endfunction

  // ordered grid near zero with random spacing, the usual boundary layout
  task automatic send_grid(logic kind);
    longint b, f1, f2, f3;
    b  = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
    f1 = b + longint'($urandom_range(1 << 12, 1 << 18));
    f2 = f1 + longint'($urandom_range(1 << 12, 1 << 18));
    f3 = f2 + longint'($urandom_range(1 << 12, 1 << 18));
    if ($urandom_range(1)) send_stencil(kind, -b, -f1, -f2, -f3);
    else send_stencil(kind, b, f1, f2, f3);
  endtask

  task automatic test_extremes();
    longint mx, mn;
    mx = (1 << (POS_W-1)) - 1;
    mn = -(1 << (POS_W-1));
    for (int k = 0; k < 2; k++) begin
      send_stencil(k[0], mn, mx, mx - 1, mn + 1);
      send_stencil(k[0], mx, mn, 0, 1);
      send_stencil(k[0], 0, 1 << POS_FRAC_BITS, 2 << POS_FRAC_BITS, 3 << POS_FRAC_BITS);
      send_stencil(k[0], -1, 1, 2, 3);
      send_stencil(k[0], mn, mn + 1, mx, -1);
    end
  endtask

  task automatic test_special_cases();
    // equal positions make a lagrange divisor zero
    send_stencil(KIND_DIRICHLET, 5 << 16, 5 << 16, 7 << 16, 9 << 16);
    send_stencil(KIND_DIRICHLET, 1 << 16, 2 << 16, 3 << 16, 3 << 16);
    // positions that are zero apart from the third give a zero neumann polynomial
    send_stencil(KIND_NEUMANN, 0, 0, 0, 0);
    send_stencil(KIND_NEUMANN, 0, 0, 0, 1 << 16);
    // closely spaced points far from zero push weights into saturation, followed by two sets of small positions
    send_stencil(KIND_DIRICHLET, 8000000, 8000001, 8000002, 8000003);
    send_stencil(KIND_NEUMANN, -8000000, -8000001, -8000002, -8000004);
    send_stencil(KIND_NEUMANN, 1, 2, 3, 5);
    send_stencil(KIND_DIRICHLET, -3, -2, -1, 4);
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 70) send_grid(1'($urandom_range(1)));
      else send_stencil(1'($urandom_range(1)), rand_pos(), rand_pos(), rand_pos(),
                        rand_pos());
    end
  endtask

  // a long burst with both sides always ready
  task automatic test_back_to_back(int count);
    no_idle = 1'b1;
    test_random_mix(count);
    wait_drained();
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_special_cases();
    // sender holds off until every outstanding result has come back
    wait_drained();
    test_random_mix(200);
    test_back_to_back(120);
    test_random_mix(180);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("sent %0d position sets, checked %0d weight sets", sent_count, checked_count);
    $display("%0d degenerate and %0d saturated results among them",
             degenerate_seen, clipped_seen);
    if (mismatches == 0 && expected_weights.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
